FILE: design/mbrsp_pkg.sv
// Package for the Modbus RTU read response builder.
// Holds payload structs, command and status codes, state type and depths.
`default_nettype none
package mbrsp_pkg;
    localparam int BitDepth  = 1024;
    localparam int WordDepth = 256;
    localparam int MaxFrame  = 64;

    localparam logic [2:0] CmdWrCoil = 3'd0;
    localparam logic [2:0] CmdWrDisc = 3'd1;
    localparam logic [2:0] CmdWrIreg = 3'd2;
    localparam logic [2:0] CmdWrHreg = 3'd3;
    localparam logic [2:0] CmdRdCoil = 3'd4;
    localparam logic [2:0] CmdRdDisc = 3'd5;
    localparam logic [2:0] CmdRdHreg = 3'd6;
    localparam logic [2:0] CmdRdIreg = 3'd7;

    // Modbus function codes of the four read commands.
    localparam logic [2:0] FcCoil = 3'd1;
    localparam logic [2:0] FcDisc = 3'd2;
    localparam logic [2:0] FcHreg = 3'd3;
    localparam logic [2:0] FcIreg = 3'd4;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StBadStart = 3'd1;
    localparam logic [2:0] StBadCount = 3'd2;
    localparam logic [2:0] StBadSpan  = 3'd3;
    localparam logic [2:0] StTooLong  = 3'd4;

    localparam logic [1:0] RegSlave = 2'd0;
    localparam logic [1:0] RegBitLim = 2'd1;
    localparam logic [1:0] RegWordLim = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] start_index;
        logic [15:0] item_count;
        logic [15:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic [2:0] status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_FETCH, S_WAIT, S_LOAD, S_CRC, S_SEND, S_ERR, S_CLEAR
    } t_state;
endpackage
`default_nettype wire

FILE: design/modbus_rtu_read_response_builder_core.sv
// Modbus RTU slave read response builder, top level; depends on mbrsp_pkg.
// An error gives a single result; a good read gives a frame; writes give none.
// Per byte: header is load, CRC merge, 8 CRC steps and send; register data adds a fetch
// (and a memory wait for the high byte), bit data a wait and fetch per bit, CRC only load and send.
// One item at a time: the next is accepted in the cycle after the last result; writes stay in idle.
// After reset a clearing pass zeroes every memory entry; the receiver cannot stall.
`default_nettype none
module modbus_rtu_read_response_builder_core #(
    parameter int BIT_DEPTH  = mbrsp_pkg::BitDepth,
    parameter int WORD_DEPTH = mbrsp_pkg::WordDepth,
    parameter int MAX_FRAME  = mbrsp_pkg::MaxFrame
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  mbrsp_pkg::t_in_item   i_item,
    input  wire                   i_cfg_we,
    input  wire [1:0]             i_cfg_index,
    input  wire [10:0]            i_cfg_data,
    output logic                  o_strobe,
    output mbrsp_pkg::t_out_item  o_item
);
    localparam int BA = (BIT_DEPTH > 1) ? $clog2(BIT_DEPTH) : 1;
    localparam int WA = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;
    localparam int CA = (BA > WA) ? BA : WA;
    localparam int CLR_LAST = ((BIT_DEPTH > WORD_DEPTH) ? BIT_DEPTH : WORD_DEPTH) - 1;

    // Memories.
    logic       coil_mem [BIT_DEPTH];
    logic       disc_mem [BIT_DEPTH];
    logic [15:0] ireg_mem [WORD_DEPTH];
    logic [15:0] hreg_mem [WORD_DEPTH];

    mbrsp_pkg::t_state r_state, n_state;
    logic [7:0]  r_slave;
    logic [10:0] r_bit_lim;
    logic [8:0]  r_word_lim;
    logic [2:0]  r_fc;
    logic [16:0] r_start, n_start;
    logic [16:0] r_count, n_count;
    logic [6:0]  r_nbytes;
    logic [6:0]  r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_bit, n_bit;
    logic [2:0]  r_status, n_status;
    logic [CA:0] r_clr, n_clr;
    logic [15:0] r_word;
    logic        r_rbit;
    logic        r_half, n_half;

    logic        is_bits;
    logic [16:0] limit;
    logic [17:0] span;
    logic [16:0] nb_calc;
    logic [6:0]  len_total;
    logic        clr_en;
    logic        wr_en;
    logic [2:0]  wr_cmd;
    logic [15:0] wr_addr;
    logic [15:0] wr_val;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave    <= 8'd1;
            r_bit_lim  <= 11'd1024;
            r_word_lim <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbrsp_pkg::RegSlave:   r_slave    <= i_cfg_data[7:0];
                mbrsp_pkg::RegBitLim:  r_bit_lim  <= i_cfg_data;
                mbrsp_pkg::RegWordLim: r_word_lim <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Store writes, from items or from the clearing pass.
    assign clr_en = (r_state == mbrsp_pkg::S_CLEAR);
    assign wr_en  = clr_en || (r_state == mbrsp_pkg::S_IDLE && start && !i_item.cmd[2]);
    assign wr_val = clr_en ? 16'd0 : i_item.entry_value;
    assign wr_addr = clr_en ? 16'(r_clr[CA-1:0]) : i_item.start_index;
    assign wr_cmd = i_item.cmd;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if ((clr_en || wr_cmd == mbrsp_pkg::CmdWrCoil) && 32'(wr_addr) < BIT_DEPTH)
                coil_mem[wr_addr[BA-1:0]] <= !clr_en && (wr_val == 16'd1);
            if ((clr_en || wr_cmd == mbrsp_pkg::CmdWrDisc) && 32'(wr_addr) < BIT_DEPTH)
                disc_mem[wr_addr[BA-1:0]] <= !clr_en && (wr_val == 16'd1);
            if ((clr_en || wr_cmd == mbrsp_pkg::CmdWrIreg) && 32'(wr_addr) < WORD_DEPTH)
                ireg_mem[wr_addr[WA-1:0]] <= wr_val;
            if ((clr_en || wr_cmd == mbrsp_pkg::CmdWrHreg) && 32'(wr_addr) < WORD_DEPTH)
                hreg_mem[wr_addr[WA-1:0]] <= wr_val;
        end
    end

    // Registered reads at the current data position.
    always_ff @(posedge i_clk) begin
        r_rbit <= (r_fc == mbrsp_pkg::FcCoil) ? coil_mem[r_start[BA-1:0]]
                                              : disc_mem[r_start[BA-1:0]];
        r_word <= (r_fc == mbrsp_pkg::FcHreg) ? hreg_mem[r_start[WA-1:0]]
                                              : ireg_mem[r_start[WA-1:0]];
    end

    // Range checks.
    assign is_bits = (r_fc <= mbrsp_pkg::FcDisc);
    always_comb begin
        if (is_bits)
            limit = (32'(r_bit_lim) < BIT_DEPTH) ? 17'(r_bit_lim) : 17'(BIT_DEPTH);
        else
            limit = (32'(r_word_lim) < WORD_DEPTH) ? 17'(r_word_lim) : 17'(WORD_DEPTH);
    end
    assign span    = 18'(r_start) + 18'(r_count);
    assign nb_calc = is_bits ? 17'((r_count + 17'd7) >> 3) : 17'(r_count << 1);
    assign len_total = r_nbytes + 7'd5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbrsp_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_count  <= n_count;
        r_pos    <= n_pos;
        r_crc    <= n_crc;
        r_byte   <= n_byte;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_half   <= n_half;
        if (r_state == mbrsp_pkg::S_IDLE && start) r_fc <= 3'(i_item.cmd - 3'd3);
        if (r_state == mbrsp_pkg::S_CHECK) r_nbytes <= nb_calc[6:0];
    end

    // Sequencer: byte assembly, bit-serial CRC and one output byte at a time.
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_start  = r_start;
        n_count  = r_count;
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_byte   = r_byte;
        n_bit    = r_bit;
        n_status = r_status;
        n_half   = r_half;
        busy     = 1'b1;
        o_strobe = 1'b0;
        o_item   = '0;
        unique case (r_state)
            mbrsp_pkg::S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == CLR_LAST) n_state = mbrsp_pkg::S_IDLE;
            end
            mbrsp_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start && i_item.cmd[2]) begin
                    n_start = {1'b0, i_item.start_index};
                    n_count = {1'b0, i_item.item_count};
                    n_state = mbrsp_pkg::S_CHECK;
                end
            end
            mbrsp_pkg::S_CHECK: begin
                priority if (r_start > limit) n_status = mbrsp_pkg::StBadStart;
                else if (r_count > limit) n_status = mbrsp_pkg::StBadCount;
                else if (span > 18'(limit)) n_status = mbrsp_pkg::StBadSpan;
                else if (nb_calc + 17'd5 > 17'(MAX_FRAME)) n_status = mbrsp_pkg::StTooLong;
                else n_status = mbrsp_pkg::StOk;
                n_pos  = '0;
                n_crc  = 16'hFFFF;
                n_half = 1'b0;
                n_state = mbrsp_pkg::S_LOAD;
                if (!(r_start > limit) && !(r_count > limit) && !(span > 18'(limit)) &&
                    (nb_calc + 17'd5 > 17'(MAX_FRAME)))
                    n_state = mbrsp_pkg::S_ERR;
                else if ((r_start > limit) || (r_count > limit) || (span > 18'(limit)))
                    n_state = mbrsp_pkg::S_ERR;
            end
            mbrsp_pkg::S_ERR: begin
                o_strobe = 1'b1;
                o_item.frame_last = 1'b1;
                o_item.status = r_status;
                n_state = mbrsp_pkg::S_IDLE;
            end
            mbrsp_pkg::S_LOAD: begin
                // Header bytes, CRC bytes, or start a data fetch.
                n_bit = '0;
                priority if (r_pos == 7'd0) begin
                    n_byte = r_slave; n_state = mbrsp_pkg::S_CRC;
                end else if (r_pos == 7'd1) begin
                    n_byte = 8'(r_fc); n_state = mbrsp_pkg::S_CRC;
                end else if (r_pos == 7'd2) begin
                    n_byte = 8'(r_nbytes); n_state = mbrsp_pkg::S_CRC;
                end else if (r_pos == len_total - 7'd2) begin
                    n_byte = r_crc[7:0]; n_state = mbrsp_pkg::S_SEND;
                end else if (r_pos == len_total - 7'd1) begin
                    n_byte = r_crc[15:8]; n_state = mbrsp_pkg::S_SEND;
                end else begin
                    n_byte = '0;
                    n_state = (is_bits || !r_half) ? mbrsp_pkg::S_WAIT : mbrsp_pkg::S_FETCH;
                end
            end
            mbrsp_pkg::S_WAIT: begin
                // Memory read of the current position lands here.
                n_state = mbrsp_pkg::S_FETCH;
            end
            mbrsp_pkg::S_FETCH: begin
                if (is_bits) begin
                    // Gather the byte one bit at a time, LSB first.
                    if (r_count != 17'd0 && 32'(r_start) < BIT_DEPTH && r_rbit)
                        n_byte = r_byte | (8'd1 << r_bit[2:0]);
                    if (r_count != 17'd0) begin
                        n_count = r_count - 1'b1;
                        n_start = r_start + 1'b1;
                    end
                    n_bit = r_bit + 1'b1;
                    if (r_bit == 4'd7) begin
                        n_bit = '0;
                        n_state = mbrsp_pkg::S_CRC;
                    end else if (r_count != 17'd0) begin
                        n_state = mbrsp_pkg::S_WAIT;
                    end
                end else begin
                    if (!r_half) begin
                        n_byte = (32'(r_start) < WORD_DEPTH) ? r_word[15:8] : 8'd0;
                        n_half = 1'b1;
                    end else begin
                        n_byte = (32'(r_start) < WORD_DEPTH) ? r_word[7:0] : 8'd0;
                        n_half = 1'b0;
                        n_start = r_start + 1'b1;
                    end
                    n_state = mbrsp_pkg::S_CRC;
                end
            end
            mbrsp_pkg::S_CRC: begin
                // One CRC bit step per cycle, byte merged on the first.
                if (r_bit == 4'd0) n_crc = r_crc ^ {8'd0, r_byte};
                else n_crc = r_crc[0] ? ((r_crc >> 1) ^ 16'hA001) : (r_crc >> 1);
                n_bit = r_bit + 1'b1;
                if (r_bit == 4'd8) begin
                    n_bit = '0;
                    n_state = mbrsp_pkg::S_SEND;
                end
            end
            mbrsp_pkg::S_SEND: begin
                o_strobe = 1'b1;
                o_item.frame_byte = r_byte;
                o_item.frame_last = (r_pos == len_total - 7'd1);
                o_item.status = mbrsp_pkg::StOk;
                n_pos = r_pos + 1'b1;
                n_state = (r_pos == len_total - 7'd1) ? mbrsp_pkg::S_IDLE : mbrsp_pkg::S_LOAD;
            end
            default: n_state = mbrsp_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
